/* rtl/core/crlmc_pkg.sv */
// ----------------------------------------------------------------------------
// crlmc_pkg
// shared constants, types and the half-round function of the chacha mask counter
// ----------------------------------------------------------------------------
package crlmc_pkg;

    localparam int unsigned COUNT_WIDTH_DEF = 40;
    localparam int unsigned OUT_COUNT_W     = 40;
    localparam int unsigned CFG_IDX_W       = 2;
    localparam int unsigned NUM_KEY_REGS    = 4;
    // half-round stages: 11 up to the end, input mask taken after stage 6
    localparam int unsigned NUM_STAGES      = 11;
    localparam int unsigned PIN_STAGE       = 6;

    localparam logic [31:0] C0 = 32'h61707865;
    localparam logic [31:0] C1 = 32'h3320646e;
    localparam logic [31:0] C2 = 32'h79622d32;
    localparam logic [31:0] C3 = 32'h6b206574;

    typedef logic [15:0][31:0] t_state;

    typedef struct packed {
        logic       restart;
        logic       pin;
        t_state     st;
    } t_cell_data;

    function automatic t_state half_step(input t_state s, input logic diag,
                                         input logic second);
        t_state r;
        int unsigned a, b, c, d;
        logic [31:0] x;
        r = s;
        for (int q = 0; q < 4; q++) begin
            a = q;
            b = diag ? 4 + ((q + 1) % 4) : 4 + q;
            c = diag ? 8 + ((q + 2) % 4) : 8 + q;
            d = diag ? 12 + ((q + 3) % 4) : 12 + q;
            r[a] = r[a] + r[b];
            x = r[d] ^ r[a];
            r[d] = second ? {x[23:0], x[31:24]} : {x[15:0], x[31:16]};
            r[c] = r[c] + r[d];
            x = r[b] ^ r[c];
            r[b] = second ? {x[24:0], x[31:25]} : {x[19:0], x[31:20]};
        end
        return r;
    endfunction

endpackage

/* rtl/core/crlmc_cell.sv */
// ----------------------------------------------------------------------------
// crlmc_cell
// one half round of the chain, registered, with a hold on stall
// ----------------------------------------------------------------------------
module crlmc_cell #(
    parameter bit DIAG   = 1'b0,
    parameter bit SECOND = 1'b0,
    parameter bit TAKE_PIN = 1'b0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  crlmc_pkg::t_cell_data i_data,
    output logic                  o_valid,
    output crlmc_pkg::t_cell_data o_data
);
    import crlmc_pkg::*;

    t_cell_data r_data, n_data;
    logic       r_valid;

    always_comb begin
        n_data     = i_data;
        n_data.st  = half_step(i_data.st, DIAG, SECOND);
        if (TAKE_PIN) begin
            n_data.pin = n_data.st[3][0] ^ n_data.st[4][0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

/* rtl/core/chacha_round_linear_mask_counter.sv */
// ----------------------------------------------------------------------------
// chacha_round_linear_mask_counter
// reduced-round chacha linear mask parity agreement counter
// ----------------------------------------------------------------------------
// One nonce word is taken per cycle while the chain advances. It runs
// through a chain of eleven half-round cells (one register each) and a final
// counting stage, the output register. The chain advances whenever the
// output register is empty or being taken. The key is to be written through
// the configuration port only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module chacha_round_linear_mask_counter #(
    parameter int unsigned COUNT_WIDTH = crlmc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [crlmc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]                    i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [127:0]                   s_axis_tdata, // nonce_low, nonce_high
    input  logic                           s_axis_tuser, // restart
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [47:0]                    m_axis_tdata  // in, out, agree, count, pad
);
    import crlmc_pkg::*;

    logic [NUM_KEY_REGS-1:0][63:0] r_key;
    logic                          en;
    logic       [NUM_STAGES:0]     v;
    t_cell_data [NUM_STAGES:0]     d;

    logic                   r_ovalid;
    logic                   r_pin, r_pout, r_agree;
    logic [COUNT_WIDTH-1:0] r_cnt, n_cnt, base;
    logic [63:0]            cnt_wide;
    logic                   pout, agree;
    t_state                 f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_we) begin
            r_key[i_cfg_idx] <= i_cfg_data;
        end
    end

    assign en            = !r_ovalid || m_axis_tready;
    assign s_axis_tready = en;

    assign d[0].restart = s_axis_tuser;
    assign d[0].pin     = 1'b0;
    assign d[0].st      = {s_axis_tdata[127:96], s_axis_tdata[95:64],
                           s_axis_tdata[63:32], s_axis_tdata[31:0],
                           r_key[3][63:32], r_key[3][31:0], r_key[2][63:32], r_key[2][31:0],
                           r_key[1][63:32], r_key[1][31:0], r_key[0][63:32], r_key[0][31:0],
                           C3, C2, C1, C0};
    assign v[0] = s_axis_tvalid;

    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_cell
        crlmc_cell #(
            .DIAG     (((g / 2) % 2) == 1),
            .SECOND   ((g % 2) == 1),
            .TAKE_PIN ((g + 1) == PIN_STAGE)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v[g]),
            .i_data  (d[g]),
            .o_valid (v[g+1]),
            .o_data  (d[g+1])
        );
    end

    always_comb begin
        f     = d[NUM_STAGES].st;
        pout  = f[0][0] ^ f[1][7] ^ f[1][0] ^ f[2][8] ^ f[2][0] ^ f[3][0]
              ^ f[4][12] ^ f[4][6] ^ f[6][12] ^ f[7][31] ^ f[7][19] ^ f[9][26]
              ^ f[11][12] ^ f[11][0] ^ f[12][23] ^ f[12][12] ^ f[12][11]
              ^ f[13][24] ^ f[13][19] ^ f[13][18] ^ f[13][16] ^ f[13][7]
              ^ f[14][0] ^ f[15][16];
        agree = (d[NUM_STAGES].pin == pout);
        base  = d[NUM_STAGES].restart ? '0 : r_cnt;
        n_cnt = (agree && (base != '1)) ? base + 1'b1 : base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
        end else if (en) begin
            r_ovalid <= v[NUM_STAGES];
            if (v[NUM_STAGES]) begin
                r_cnt <= n_cnt;
            end
        end
        if (en && v[NUM_STAGES]) begin
            r_pin   <= d[NUM_STAGES].pin;
            r_pout  <= pout;
            r_agree <= agree;
        end
    end

    assign cnt_wide      = 64'(r_cnt);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'd0, cnt_wide[OUT_COUNT_W-1:0], r_agree, r_pout, r_pin};
endmodule
